// File: design/y411_pkg.sv
// Shared constants, types and helpers of the y411 to RGB unpacker.
`timescale 1ns / 1ps
package y411_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int POS_LIMIT     = 4096;
  localparam int POS_W         = 12;
  localparam int DIM_W         = 13;
  localparam int CFG_INDEX_W   = 2;
  localparam int LANES         = 4;
  localparam int LANE_IDX_W    = $clog2(LANES);
  localparam int TERM_W        = 19;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic signed [TERM_W-1:0] COEF_Y  = 19'sd298;
  localparam logic signed [TERM_W-1:0] COEF_VR = 19'sd409;
  localparam logic signed [TERM_W-1:0] COEF_UG = 19'sd100;
  localparam logic signed [TERM_W-1:0] COEF_VG = 19'sd208;
  localparam logic signed [TERM_W-1:0] COEF_UB = 19'sd516;
  localparam logic signed [TERM_W-1:0] ROUND   = 19'sd128;
  localparam logic signed [9:0]        LUMA_OFFSET   = 10'sd16;
  localparam logic signed [9:0]        CHROMA_OFFSET = 10'sd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Position and end-of-frame tag that travels with one group.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             fend;
  } group_tag_t;

  localparam int DIM_CAP = (MAX_DIMENSION < POS_LIMIT) ? MAX_DIMENSION : POS_LIMIT;

  // Saturate a dimension register to 2..DIM_CAP and force it even.
  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] value);
    logic [DIM_W-1:0] v;
    v = value;
    if (v > DIM_W'(DIM_CAP)) v = DIM_W'(DIM_CAP);
    if (v < DIM_W'(2)) v = DIM_W'(2);
    return {v[DIM_W-1:1], 1'b0};
  endfunction

endpackage

// File: design/y411_if.sv
// Valid/ready channel interfaces for groups in and pixels out.
`timescale 1ns / 1ps
interface y411_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chroma_u;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] chroma_v;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;

  modport source (output valid, chroma_u, luma_top_left, luma_top_right, chroma_v,
                  luma_bottom_left, luma_bottom_right, input ready);
  modport sink (input valid, chroma_u, luma_top_left, luma_top_right, chroma_v,
                luma_bottom_left, luma_bottom_right, output ready);
endinterface

interface y411_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] pixel_row;
  logic [11:0] pixel_column;
  logic        last_of_group;
  logic        frame_end;

  modport source (output valid, red, green, blue, pixel_row, pixel_column,
                  last_of_group, frame_end, input ready);
  modport sink (input valid, red, green, blue, pixel_row, pixel_column,
                last_of_group, frame_end, output ready);
endinterface

// File: design/y411_lane.sv
// One conversion lane: luma plus shared chroma to a clamped RGB888 pixel.
`timescale 1ns / 1ps
module y411_lane
  import y411_pkg::*;
(
  input  logic       clk,
  input  logic       s1_en,
  input  logic       s2_en,
  input  logic [7:0] luma,
  input  logic [7:0] chroma_u,
  input  logic [7:0] chroma_v,
  output rgb_t       pixel
);

  logic signed [9:0]        c, d, e;
  logic signed [TERM_W-1:0] y_term_r, vr_term_r, ug_term_r, vg_term_r, ub_term_r;
  logic signed [TERM_W-1:0] sum_r, sum_g, sum_b;
  rgb_t                     pixel_r;

  // Floor shift by 8, then clamp to 0..255.
  function automatic logic [7:0] shift_clamp(input logic signed [TERM_W-1:0] x);
    logic signed [TERM_W-9:0] q;
    q = x[TERM_W-1:8];
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  assign c = $signed({2'b00, luma}) - LUMA_OFFSET;
  assign d = $signed({2'b00, chroma_u}) - CHROMA_OFFSET;
  assign e = $signed({2'b00, chroma_v}) - CHROMA_OFFSET;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      y_term_r  <= TERM_W'(c) * COEF_Y;
      vr_term_r <= TERM_W'(e) * COEF_VR;
      ug_term_r <= TERM_W'(d) * COEF_UG;
      vg_term_r <= TERM_W'(e) * COEF_VG;
      ub_term_r <= TERM_W'(d) * COEF_UB;
    end
  end

  assign sum_r = y_term_r + vr_term_r + ROUND;
  assign sum_g = y_term_r - ug_term_r - vg_term_r + ROUND;
  assign sum_b = y_term_r + ub_term_r + ROUND;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      pixel_r.red   <= shift_clamp(sum_r);
      pixel_r.green <= shift_clamp(sum_g);
      pixel_r.blue  <= shift_clamp(sum_b);
    end
  end

  assign pixel = pixel_r;

endmodule

// File: design/y411_merge.sv
// Merge stage: hold the four lane pixels of a group, send one a cycle when ready.
`timescale 1ns / 1ps
module y411_merge
  import y411_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_valid,
  output logic            load_ready,
  input  rgb_t            lane_pixel [LANES],
  input  group_tag_t      load_tag,
  y411_out_if.source      out_ch
);

  rgb_t                  buf_r [LANES];
  group_tag_t            tag_r;
  logic                  full_r, full_nxt;
  logic [LANE_IDX_W-1:0] idx_r, idx_nxt;
  logic                  out_take, last_take, load;

  assign out_take   = full_r && out_ch.ready;
  assign last_take  = out_take && (idx_r == LANE_IDX_W'(LANES - 1));
  assign load_ready = !full_r || last_take;
  assign load       = load_valid && load_ready;

  always_comb begin
    full_nxt = full_r;
    idx_nxt  = idx_r;
    if (out_take) idx_nxt = idx_r + 1'b1;
    if (last_take) full_nxt = 1'b0;
    if (load) begin
      full_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= lane_pixel;
      tag_r <= load_tag;
    end
  end

  // Lane order is TL, TR, BL, BR: bit 1 of the index picks the row, bit 0 the column.
  assign out_ch.valid         = full_r;
  assign out_ch.red           = buf_r[idx_r].red;
  assign out_ch.green         = buf_r[idx_r].green;
  assign out_ch.blue          = buf_r[idx_r].blue;
  assign out_ch.pixel_row     = tag_r.row + POS_W'(idx_r[1]);
  assign out_ch.pixel_column  = tag_r.col + POS_W'(idx_r[0]);
  assign out_ch.last_of_group = (idx_r == LANE_IDX_W'(LANES - 1));
  assign out_ch.frame_end     = (idx_r == LANE_IDX_W'(LANES - 1)) && tag_r.fend;

endmodule

// File: design/y411_to_rgb_unpacker.sv
// Top level of the y411 group to RGB888 unpacker.
//
// Usage: each request on in_ch carries one packed 2x2 group (u, y0, y1, v, y2,
// y3). The block answers with four RGB888 pixel requests on out_ch in the order
// top-left, top-right, bottom-left, bottom-right, each tagged with its row and
// column; last_of_group marks the fourth pixel, frame_end the fourth pixel of
// the group that closes the frame, after which positions wrap to 0,0.
// Each accepted group passes the product stage, the sum/clamp stage and the
// merge buffer before its first pixel is offered; its pixels then leave one per
// cycle while out_ch.ready is high, so the output channel draining the merge
// buffer sets the group rate; four lanes convert the whole group at once.
// A new group is taken while the previous one is still being sent.
// Reset (rst_n low, synchronous) empties the pipeline, sets the position to 0,0
// and the frame size to 640x480. When the receiver stalls, the pipeline fills
// and in_ch.ready drops; nothing is lost. Write cfg registers only while idle.
`timescale 1ns / 1ps
module y411_to_rgb_unpacker
  import y411_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_wdata,
  y411_in_if.sink                in_ch,
  y411_out_if.source             out_ch
);

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [DIM_W-1:0] eff_width, eff_height;
  logic [POS_W-1:0] group_column_r, group_column_nxt;
  logic [POS_W-1:0] group_row_r, group_row_nxt;
  logic [DIM_W-1:0] col_step, row_step;
  logic             fend_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s2_valid_r, s2_valid_nxt;
  group_tag_t s1_tag_r, s2_tag_r;
  logic       in_take, s1_move, s2_move, merge_ready;
  rgb_t       lane_pixel [LANES];
  logic [7:0] lane_luma  [LANES];

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_width  = effective_dim(frame_width_r);
  assign eff_height = effective_dim(frame_height_r);

  // Advance the group position by one 2x2 block; wrap at the frame edges.
  always_comb begin
    col_step         = {1'b0, group_column_r} + DIM_W'(2);
    row_step         = {1'b0, group_row_r} + DIM_W'(2);
    group_column_nxt = col_step[POS_W-1:0];
    group_row_nxt    = group_row_r;
    fend_nxt         = 1'b0;
    if (col_step >= eff_width) begin
      group_column_nxt = '0;
      group_row_nxt    = row_step[POS_W-1:0];
      if (row_step >= eff_height) begin
        group_row_nxt = '0;
        fend_nxt      = 1'b1;
      end
    end
  end

  // Pipeline flow: a stage moves on when the one ahead is empty or moving.
  assign s2_move     = s2_valid_r && merge_ready;
  assign s1_move     = s1_valid_r && (!s2_valid_r || s2_move);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (s1_move) s1_valid_nxt = 1'b0;
    if (in_take) s1_valid_nxt = 1'b1;
    if (s2_move) s2_valid_nxt = 1'b0;
    if (s1_move) s2_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      group_column_r <= '0;
      group_row_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (in_take) begin
        group_column_r <= group_column_nxt;
        group_row_r    <= group_row_nxt;
      end
    end
  end

  // Tag follows the group down the lanes.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tag_r.row  <= group_row_r;
      s1_tag_r.col  <= group_column_r;
      s1_tag_r.fend <= fend_nxt;
    end
    if (s1_move) s2_tag_r <= s1_tag_r;
  end

  assign lane_luma[0] = in_ch.luma_top_left;
  assign lane_luma[1] = in_ch.luma_top_right;
  assign lane_luma[2] = in_ch.luma_bottom_left;
  assign lane_luma[3] = in_ch.luma_bottom_right;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    y411_lane u_lane (
      .clk      (clk),
      .s1_en    (in_take),
      .s2_en    (s1_move),
      .luma     (lane_luma[i]),
      .chroma_u (in_ch.chroma_u),
      .chroma_v (in_ch.chroma_v),
      .pixel    (lane_pixel[i])
    );
  end

  y411_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s2_valid_r),
    .load_ready (merge_ready),
    .lane_pixel (lane_pixel),
    .load_tag   (s2_tag_r),
    .out_ch     (out_ch)
  );

  // The fourth pixel of a group sits at odd row and odd column.
  a_last_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_group |-> out_ch.pixel_row[0] && out_ch.pixel_column[0])
    else $error("last pixel of group not at odd row and column");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_end |-> out_ch.last_of_group)
    else $error("frame end flagged on a non-final pixel of a group");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted group did not enter the product stage");

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && fend_nxt |=> group_column_r == '0 && group_row_r == '0)
    else $error("position did not wrap after the frame's last group");

endmodule

// File: bench/y411_to_rgb_unpacker_tb.sv
// Self-checking testbench for the y411 group to RGB888 unpacker.
`timescale 1ns / 1ps
module y411_to_rgb_unpacker_tb
  import y411_pkg::*;
();

  // Indexes past the register list; writes there must leave the frame size alone.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;    // pipeline is 3 deep; allow some slack
  localparam int BACKLOG_CYCLES = 160;  // long receiver hold-off for the pressure phase
  localparam int RANDOM_GROUPS  = 250;
  // Quiet-cycle budget: the backlog hold plus the longest random stalls, several times over.
  localparam int WATCHDOG_LIMIT = 3000;

  // One packed 2x2 group, fields in wire order.
  typedef struct packed {
    logic [7:0] chroma_u;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] chroma_v;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
  } group_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             fend;
  } pixel_t;

  // A directed row: the group, and where the colour is obvious, the level that all
  // four pixels must show on red, green and blue alike.
  typedef struct packed {
    group_t     grp;
    logic       typed;
    logic [7:0] level;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  y411_in_if  in_ch ();
  y411_out_if out_ch ();

  y411_to_rgb_unpacker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow of the block: frame size registers and position of the next group.
  logic [DIM_W-1:0] shadow_width;
  logic [DIM_W-1:0] shadow_height;
  int               next_group_col;
  int               next_group_row;

  pixel_t    pending_pixels [$];
  stim_row_t directed_rows [12];

  int  mismatches;
  int  groups_sent;
  int  pixels_checked;
  int  frames_closed;
  int  settings_used;
  int  quiet_cycles;
  int  backlog_requests;
  int  backlog_served;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor-divide by 256 and clamp to a byte.
  function automatic logic [7:0] scale_clamp(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Saturate a size register to 2..4096 and drop its odd bit.
  function automatic int usable_dim(input logic [DIM_W-1:0] r);
    int v;
    v = r;
    if (v > MAX_DIMENSION) v = MAX_DIMENSION;
    if (v > POS_LIMIT) v = POS_LIMIT;
    if (v < 2) v = 2;
    return v & ~1;
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] luma, input int d, input int e,
                                        input int row, input int col, input bit last,
                                        input bit fend, input bit typed,
                                        input logic [7:0] level);
    pixel_t p;
    int c;
    c = luma;
    c = c - 16;
    // Integer BT.601 with +128 rounding.
    p.red   = scale_clamp(298 * c + 409 * e + 128);
    p.green = scale_clamp(298 * c - 100 * d - 208 * e + 128);
    p.blue  = scale_clamp(298 * c + 516 * d + 128);
    if (typed) begin
      p.red   = level;
      p.green = level;
      p.blue  = level;
    end
    p.row  = POS_W'(row);
    p.col  = POS_W'(col);
    p.last = last;
    p.fend = fend;
    return p;
  endfunction

  // Queue the four pixels of one accepted group and advance the shadow position.
  function automatic void predict_group(input group_t g, input bit typed,
                                        input logic [7:0] level);
    int w;
    int h;
    int col;
    int row;
    int next_col;
    int next_row;
    int d;
    int e;
    bit closes;
    w = usable_dim(shadow_width);
    h = usable_dim(shadow_height);
    col = next_group_col;
    row = next_group_row;
    d = g.chroma_u;
    d = d - 128;
    e = g.chroma_v;
    e = e - 128;
    next_col = col + 2;
    next_row = row;
    closes = 1'b0;
    // Wrap on or past the edge, so a position left over from a larger frame
    // closes its frame at once.
    if (next_col >= w) begin
      next_col = 0;
      next_row = row + 2;
      if (next_row >= h) begin
        next_row = 0;
        closes = 1'b1;
      end
    end
    pending_pixels.push_back(make_pixel(g.luma_top_left, d, e, row, col, 1'b0, 1'b0,
                                        typed, level));
    pending_pixels.push_back(make_pixel(g.luma_top_right, d, e, row, col + 1, 1'b0, 1'b0,
                                        typed, level));
    pending_pixels.push_back(make_pixel(g.luma_bottom_left, d, e, row + 1, col, 1'b0,
                                        1'b0, typed, level));
    pending_pixels.push_back(make_pixel(g.luma_bottom_right, d, e, row + 1, col + 1, 1'b1,
                                        closes, typed, level));
    next_group_col = next_col;
    next_group_row = next_row;
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Lean on the range ends and on the BT.601 black and white levels.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      default: return 8'($urandom);
    endcase
  endfunction

  // Small frames most of the time so that frame ends come often.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return DIM_W'(0);
      1: return DIM_W'(1);
      2: return DIM_W'(MAX_DIMENSION);
      3: return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(2, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input pixel_t ref_px);
    if (got != want)
      note_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                              name, ref_px.row, ref_px.col, got, want));
  endtask

  // Compare every accepted pixel against the oldest expectation.
  always @(posedge clk) begin : pixel_check
    pixel_t seen;
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.red   = out_ch.red;
      seen.green = out_ch.green;
      seen.blue  = out_ch.blue;
      seen.row   = out_ch.pixel_row;
      seen.col   = out_ch.pixel_column;
      seen.last  = out_ch.last_of_group;
      seen.fend  = out_ch.frame_end;
      if (seen.fend) frames_closed++;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel at row %0d col %0d", seen.row, seen.col));
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        check_field("red", seen.red, want.red, want);
        check_field("green", seen.green, want.green, want);
        check_field("blue", seen.blue, want.blue, want);
        check_field("pixel_row", seen.row, want.row, want);
        check_field("pixel_column", seen.col, want.col, want);
        check_field("last_of_group", seen.last, want.last, want);
        check_field("frame_end", seen.fend, want.fend, want);
      end
    end
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("y411_to_rgb_unpacker_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (backlog_served != backlog_requests) begin
        // Hold off long enough for the pipeline to fill and stall the input side.
        backlog_served++;
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one group, hold it until accepted, then predict its pixels.
  // Valid is left high so a back-to-back request needs no second assignment.
  task automatic send_group(input group_t g, input bit typed, input logic [7:0] level);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.chroma_u          <= g.chroma_u;
    in_ch.luma_top_left     <= g.luma_top_left;
    in_ch.luma_top_right    <= g.luma_top_right;
    in_ch.chroma_v          <= g.chroma_v;
    in_ch.luma_bottom_left  <= g.luma_bottom_left;
    in_ch.luma_bottom_right <= g.luma_bottom_right;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_group(g, typed, level);
    groups_sent++;
  endtask

  task automatic send_random_group();
    group_t g;
    g.chroma_u          = pick_byte();
    g.luma_top_left     = pick_byte();
    g.luma_top_right    = pick_byte();
    g.chroma_v          = pick_byte();
    g.luma_bottom_left  = pick_byte();
    g.luma_bottom_right = pick_byte();
    send_group(g, 1'b0, 8'd0);
  endtask

  // Drop valid, wait for every expected pixel, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the frame size; optionally poke the unused indexes afterward.
  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE_LO;
      cfg_wdata <= DIM_W'($urandom);
      @(posedge clk);
      cfg_index <= REG_SPARE_HI;
      cfg_wdata <= DIM_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow_width  = w;
    shadow_height = h;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int burst;
    int random_sent;
    int phase;

    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = REG_FRAME_WIDTH;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.chroma_u          = '0;
    in_ch.luma_top_left     = '0;
    in_ch.luma_top_right    = '0;
    in_ch.chroma_v          = '0;
    in_ch.luma_bottom_left  = '0;
    in_ch.luma_bottom_right = '0;
    mismatches       = 0;
    groups_sent      = 0;
    pixels_checked   = 0;
    frames_closed    = 0;
    settings_used    = 1;
    quiet_cycles     = 0;
    backlog_requests = 0;
    backlog_served   = 0;
    steady           = 1'b0;
    shadow_width     = WIDTH_RESET;
    shadow_height    = HEIGHT_RESET;
    next_group_col   = 0;
    next_group_row   = 0;

    // Columns: u, y top-left, y top-right, v, y bottom-left, y bottom-right,
    // typed flag, level on all of red/green/blue.
    directed_rows = '{
      {8'd128, 8'd16,  8'd16,  8'd128, 8'd16,  8'd16,  1'b1, 8'd0},    // black level
      {8'd128, 8'd235, 8'd235, 8'd128, 8'd235, 8'd235, 1'b1, 8'd255},  // white level
      {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
      {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
      {8'd0,   8'd128, 8'd128, 8'd255, 8'd128, 8'd128, 1'b0, 8'd0},
      {8'd255, 8'd128, 8'd128, 8'd0,   8'd128, 8'd128, 1'b0, 8'd0},
      {8'd128, 8'd0,   8'd255, 8'd128, 8'd255, 8'd0,   1'b0, 8'd0},
      {8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
      {8'd255, 8'd16,  8'd16,  8'd255, 8'd16,  8'd16,  1'b0, 8'd0},
      {8'd128, 8'd15,  8'd17,  8'd128, 8'd236, 8'd234, 1'b0, 8'd0},  // around the clamp
      {8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  1'b0, 8'd0},
      {8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 8'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset frame size, position starting at the origin.
    foreach (directed_rows[i])
      send_group(directed_rows[i].grp, directed_rows[i].typed, directed_rows[i].level);

    // Shrink to the smallest frame while mid-row: the stale position must
    // report where it was and close the frame at once; then every group closes one.
    settle();
    write_dims(DIM_W'(2), DIM_W'(2), 1'b0);
    repeat (6) send_random_group();

    // Below range on both axes (saturates to 2x2), plus writes to unused indexes.
    settle();
    write_dims(DIM_W'(0), DIM_W'(1), 1'b1);
    repeat (4) send_random_group();

    // Above range on both axes, saturating to the largest frame.
    settle();
    write_dims(DIM_W'(8191), DIM_W'(MAX_DIMENSION + 1), 1'b0);
    repeat (6) send_random_group();

    // Odd sizes lose their low bit: 7x5 behaves as 6x4.
    settle();
    write_dims(DIM_W'(7), DIM_W'(5), 1'b1);
    repeat (14) send_random_group();

    // Random phases: new frame size each time, mixed pacing, one backlog phase.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_GROUPS) begin
      settle();
      write_dims(pick_dim(), pick_dim(), $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 4) == 0);
      if (phase == 1) begin
        steady = 1'b1;
        backlog_requests++;
      end
      burst = $urandom_range(10, 40);
      repeat (burst) send_random_group();
      random_sent += burst;
      phase++;
    end

    steady = 1'b0;
    settle();
    $display("covered %0d groups over %0d frame settings: %0d pixels compared, %0d frame ends",
             groups_sent, settings_used, pixels_checked, frames_closed);
    $display("including size saturation, odd sizes, stale positions and a %0d-cycle backlog",
             BACKLOG_CYCLES);
    if (mismatches == 0) begin
      $display("y411_to_rgb_unpacker_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("y411_to_rgb_unpacker_tb failed");
    end
    $finish;
  end

endmodule
